// ===== rtl/mwr_pkg.sv =====
// shared types and constants for the microwire eeprom read master
// no dependencies; imported by mwr_core and microwire_eeprom_read_master

package mwr_pkg;

    localparam int DATA_BITS = 16;

    localparam int WORD_W    = 16;
    localparam int OFFSET_W  = 8;
    localparam int TIMEOUT_W = 14;
    localparam int INDEX_W   = 5;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;
    localparam int ADDR_W    = 3;
    localparam int PDATA_W   = 32;

    localparam logic [2:0]          OPC_READ       = 3'b110;
    localparam logic [WORD_W-1:0]   WORD_ALL_ONES  = 16'hFFFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 14'd10000;
    localparam logic [3:0]          ABITS_NARROW   = 4'd6;
    localparam logic [3:0]          ABITS_WIDE     = 4'd8;

    // register select is paddr[2]
    localparam logic REG_WIDE_ADDRESS  = 1'b0;
    localparam logic REG_GRANT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic                  wide_address;
        logic [TIMEOUT_W-1:0]  grant_timeout;
    } cfg_t;

    typedef struct packed {
        logic                  serial_data_out;
        logic                  grant;
        logic [OFFSET_W-1:0]   word_offset;
        logic                  start_read;
    } in_item_t;

    typedef struct packed {
        logic                  grant_timed_out;
        logic [WORD_W-1:0]     read_word;
        logic                  read_done;
        logic                  busy_res;
        logic                  access_request;
        logic                  serial_data_in;
        logic                  serial_clock;
        logic                  chip_select;
    } res_item_t;

endpackage

// ===== rtl/microwire_eeprom_read_master.sv =====
// top level: stream input/result registers, apb config registers, sequencer
// depends on mwr_pkg and mwr_core
// a tick transaction accepted into the input register has its result registered in the
// result register once that register is free or being drained; m_tvalid shows it held
// throughput: one tick per cycle while the result register is free or m_tready is high;
// the whole step is one pass through mwr_core
// reset: aresetn synchronous active low; clears handshake, config to defaults, sequencer idle
// no clearing pass; config registers reset to six address bits and 10000 tick timeout

module microwire_eeprom_read_master (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tick input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_read[0], word_offset[8:1], grant[9], serial_data_out[10], zero[15:11]
    input  logic [mwr_pkg::IN_W-1:0]        s_tdata,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chip_select[0], serial_clock[1], serial_data_in[2], access_request[3],
    // busy_res[4], read_done[5], read_word[21:6], grant_timed_out[22], zero[23]
    output logic [mwr_pkg::OUT_W-1:0]       m_tdata,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mwr_pkg::ADDR_W-1:0]      paddr,
    input  logic [mwr_pkg::PDATA_W-1:0]     pwdata,
    output logic [mwr_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import mwr_pkg::*;

    // input register holds one accepted tick transaction
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    // result register
    logic       out_valid_reg;
    res_item_t  out_item_reg;

    cfg_t       cfg_reg;
    res_item_t  step_res;
    logic       advance;
    logic       cfg_write;

    // a held tick moves on whenever the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata[10:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_item_reg};

    // config registers, written in the apb access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_address  <= 1'b0;
            cfg_reg.grant_timeout <= TIMEOUT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_WIDE_ADDRESS:  cfg_reg.wide_address  <= pwdata[0];
                REG_GRANT_TIMEOUT: cfg_reg.grant_timeout <= pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDE_ADDRESS:  prdata = PDATA_W'(cfg_reg.wide_address);
            REG_GRANT_TIMEOUT: prdata = PDATA_W'(cfg_reg.grant_timeout);
            default:           prdata = '0;
        endcase
    end

    // one tick of the read sequence per advance
    mwr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .res     (step_res)
    );

`ifndef SYNTHESIS
    // timeout flag only ever rides with a finished read
    a_tmo_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.grant_timed_out) |-> out_item_reg.read_done)
        else $error("timeout flag without read_done");

    // word is zero on every tick that does not finish a read
    a_word_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_item_reg.read_done) |-> (out_item_reg.read_word == '0))
        else $error("read_word nonzero outside read_done");

    // a finishing tick releases the bus: idle and request dropped
    a_done_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.read_done)
            |-> (!out_item_reg.busy_res && !out_item_reg.access_request))
        else $error("read_done while still busy or requesting");
`endif

endmodule

// ===== rtl/mwr_core.sv =====
// tick sequencer for the microwire read: phase, bit counters, pin levels
// depends on mwr_pkg; advances one tick whenever step is high

module mwr_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  mwr_pkg::cfg_t      cfg,
    input  mwr_pkg::in_item_t  item,
    output mwr_pkg::res_item_t res
);
    import mwr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_SELECT, PH_CMD, PH_READ, PH_DESEL, PH_FINISH
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [INDEX_W-1:0]    bit_index_reg, bit_index_next;
    logic [1:0]            sub_step_reg, sub_step_next;
    logic [TIMEOUT_W-1:0]  wait_count_reg, wait_count_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [WORD_W-1:0]     shift_reg, shift_next;
    logic                  cs_reg, cs_next;
    logic                  sk_reg, sk_next;
    logic                  di_reg, di_next;
    logic                  rq_reg, rq_next;

    logic [3:0]            abits;
    logic [INDEX_W-1:0]    total;
    logic [INDEX_W-1:0]    bit_inc;
    logic [INDEX_W-1:0]    addr_k;
    logic [INDEX_W-1:0]    addr_pos;
    logic                  cmd_bit;
    logic                  done;
    logic [WORD_W-1:0]     word;
    logic                  tmo;

    assign abits   = cfg.wide_address ? ABITS_WIDE : ABITS_NARROW;
    assign total   = INDEX_W'(abits) + INDEX_W'(3);
    assign bit_inc = bit_index_reg + INDEX_W'(1);
    assign addr_k  = bit_index_reg - INDEX_W'(3);
    assign addr_pos = INDEX_W'(abits) - INDEX_W'(1) - addr_k;

    // opcode first, then address msb first, zero past the current width
    always_comb begin
        if (bit_index_reg < INDEX_W'(3)) begin
            cmd_bit = OPC_READ[2'd2 - bit_index_reg[1:0]];
        end else if (addr_k >= INDEX_W'(abits)) begin
            cmd_bit = 1'b0;
        end else begin
            cmd_bit = offset_reg[addr_pos[2:0]];
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        sub_step_next   = sub_step_reg;
        wait_count_next = wait_count_reg;
        offset_next     = offset_reg;
        shift_next      = shift_reg;
        cs_next         = cs_reg;
        sk_next         = sk_reg;
        di_next         = di_reg;
        rq_next         = rq_reg;
        done            = 1'b0;
        word            = '0;
        tmo             = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (item.start_read) begin
                    offset_next     = item.word_offset;
                    wait_count_next = '0;
                    shift_next      = '0;
                    rq_next         = 1'b1;
                    phase_next      = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (item.grant) begin
                    cs_next    = 1'b0;
                    sk_next    = 1'b0;
                    phase_next = PH_SELECT;
                end else if (({1'b0, wait_count_reg} + (TIMEOUT_W+1)'(1))
                             >= {1'b0, cfg.grant_timeout}) begin
                    rq_next    = 1'b0;
                    done       = 1'b1;
                    word       = WORD_ALL_ONES;
                    tmo        = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    wait_count_next = wait_count_reg + TIMEOUT_W'(1);
                end
            end
            PH_SELECT: begin
                cs_next        = 1'b1;
                bit_index_next = '0;
                sub_step_next  = '0;
                phase_next     = PH_CMD;
            end
            PH_CMD: begin
                if (sub_step_reg == 2'd0) begin
                    di_next       = cmd_bit;
                    sub_step_next = 2'd1;
                end else if (sub_step_reg == 2'd1) begin
                    sk_next       = 1'b1;
                    sub_step_next = 2'd2;
                end else begin
                    sk_next       = 1'b0;
                    sub_step_next = 2'd0;
                    if (bit_inc >= total) begin
                        bit_index_next = '0;
                        phase_next     = PH_READ;
                    end else begin
                        bit_index_next = bit_inc;
                    end
                end
            end
            PH_READ: begin
                if (sub_step_reg == 2'd0) begin
                    sk_next       = 1'b1;
                    shift_next    = {shift_reg[WORD_W-2:0], item.serial_data_out};
                    sub_step_next = 2'd1;
                end else begin
                    sk_next       = 1'b0;
                    sub_step_next = 2'd0;
                    if (bit_inc >= INDEX_W'(DATA_BITS)) begin
                        bit_index_next = '0;
                        phase_next     = PH_DESEL;
                    end else begin
                        bit_index_next = bit_inc;
                    end
                end
            end
            PH_DESEL: begin
                cs_next    = 1'b0;
                phase_next = PH_FINISH;
            end
            default: begin
                rq_next    = 1'b0;
                done       = 1'b1;
                word       = shift_reg;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            sub_step_reg   <= '0;
            wait_count_reg <= '0;
            offset_reg     <= '0;
            shift_reg      <= '0;
            cs_reg         <= 1'b0;
            sk_reg         <= 1'b0;
            di_reg         <= 1'b0;
            rq_reg         <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            sub_step_reg   <= sub_step_next;
            wait_count_reg <= wait_count_next;
            offset_reg     <= offset_next;
            shift_reg      <= shift_next;
            cs_reg         <= cs_next;
            sk_reg         <= sk_next;
            di_reg         <= di_next;
            rq_reg         <= rq_next;
        end
    end

    assign res.chip_select     = cs_next;
    assign res.serial_clock    = sk_next;
    assign res.serial_data_in  = di_next;
    assign res.access_request  = rq_next;
    assign res.busy_res        = (phase_next != PH_IDLE);
    assign res.read_done       = done;
    assign res.read_word       = word;
    assign res.grant_timed_out = tmo;

`ifndef SYNTHESIS
    // select is up whenever the command or data is shifting
    a_cs_in_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CMD || phase_reg == PH_READ) |-> cs_reg)
        else $error("chip select low during transfer");

    // request stays high for the whole read
    a_rq_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> rq_reg)
        else $error("request dropped mid read");

    // command bit counter never runs past the longest command
    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CMD) |-> (bit_index_reg <= INDEX_W'(11)))
        else $error("command bit index out of range");
`endif

endmodule
